### design/hld_pkg.sv
package hld_pkg;

    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 31;
    localparam int SLOPE_BITS = 17;

    localparam logic [15:0] DELTA_RESET = 16'd256;
    localparam logic [16:0] SLOPE_ONE   = 17'd65536;

    // payload carried down the row of cells
    typedef struct packed {
        logic [31:0] e;
        logic [15:0] d;
        logic        inlier;
        logic [33:0] rem_s;
        logic [31:0] root;
        logic [33:0] value;
        logic [31:0] div_s;
        logic [31:0] rem_sl;
        logic [16:0] q_sl;
        logic [63:0] div_c;
        logic [63:0] rem_c;
        logic [30:0] q_c;
    } pipe_t;

endpackage

### design/hld_sqrt_cell.sv
module hld_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          up_valid,
    input  hld_pkg::pipe_t up_data,
    output logic          up_ready,
    output logic          valid,
    output hld_pkg::pipe_t data,
    input  logic          down_ready
);
    import hld_pkg::*;

    localparam bool_has = (STEP >= 16);
    localparam int  LO  = bool_has ? 2 * (STEP - 16) : 0;

    logic        valid_reg;
    pipe_t       data_reg;
    pipe_t       data_next;
    logic [1:0]  pair;
    logic [35:0] rem_sh;
    logic [35:0] trial;

    // one result bit of the root per cell
    always_comb
    begin
        data_next = up_data;
        pair      = bool_has ? up_data.e[LO+1:LO] : 2'b00;
        rem_sh    = {up_data.rem_s, pair};
        trial     = {2'b00, up_data.root, 2'b01};
        if (rem_sh >= trial)
        begin
            data_next.rem_s = 34'(rem_sh - trial);
            data_next.root  = {up_data.root[30:0], 1'b1};
        end
        else
        begin
            data_next.rem_s = rem_sh[33:0];
            data_next.root  = {up_data.root[30:0], 1'b0};
        end
    end

    assign up_ready = !valid_reg || down_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready)
            data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

### design/hld_div_cell.sv
module hld_div_cell #(
    parameter int STEP = 0
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          up_valid,
    input  hld_pkg::pipe_t up_data,
    output logic          up_ready,
    output logic          valid,
    output hld_pkg::pipe_t data,
    input  logic          down_ready
);
    import hld_pkg::*;

    localparam bit SLOPE_ON = (STEP < SLOPE_BITS);

    logic        valid_reg;
    pipe_t       data_reg;
    pipe_t       data_next;
    logic [32:0] sh_sl;
    logic [64:0] sh_c;

    // one quotient bit per lane, slope only when STEP < SLOPE_BITS; the dividends have only zeros below
    always_comb
    begin
        data_next = up_data;
        sh_c      = {up_data.rem_c, 1'b0};
        if (sh_c >= {1'b0, up_data.div_c})
        begin
            data_next.rem_c = 64'(sh_c - {1'b0, up_data.div_c});
            data_next.q_c   = {up_data.q_c[29:0], 1'b1};
        end
        else
        begin
            data_next.rem_c = sh_c[63:0];
            data_next.q_c   = {up_data.q_c[29:0], 1'b0};
        end
        sh_sl = {up_data.rem_sl, 1'b0};
        if (SLOPE_ON)
        begin
            if (sh_sl >= {1'b0, up_data.div_s})
            begin
                data_next.rem_sl = 32'(sh_sl - {1'b0, up_data.div_s});
                data_next.q_sl   = {up_data.q_sl[15:0], 1'b1};
            end
            else
            begin
                data_next.rem_sl = sh_sl[31:0];
                data_next.q_sl   = {up_data.q_sl[15:0], 1'b0};
            end
        end
    end

    assign up_ready = !valid_reg || down_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready)
            data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

### design/huber_loss_with_derivatives.sv
// Huber robust loss with first and second derivative, one request per cycle unless stalled.
// Request channel: req_valid/req_ready with sq_error (unsigned Q16.16).
// Response channel: rsp_valid/rsp_ready with value (Q18.16), slope (Q1.16)
// and curvature (signed Q16.16, never positive).
// Threshold delta (Q8.8) is written through cfg_we/cfg_wdata; the user
// must write it only while idle, as the block does not enforce this.
// A request passes one entry stage, 32 square root cells (one root bit
// each), one multiply stage, 31 divider cells (one curvature quotient bit
// each, plus a slope bit in the last SLOPE_BITS) and the output register.
// Throughput is one request per cycle while the receiver keeps up; each
// cell takes new data whenever it is empty or its neighbor moves on, so
// bubbles are squeezed out. When the receiver stalls, results pile up cell
// by cell and req_ready drops only once every cell is full. Reset empties the pipeline and sets delta to 1.0.
module huber_loss_with_derivatives (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_wdata,
    input  logic               req_valid,
    output logic               req_ready,
    input  logic [31:0]        sq_error,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output logic [33:0]        value,
    output logic [16:0]        slope,
    output logic signed [31:0] curvature
);
    import hld_pkg::*;

    logic [15:0] delta_reg;

    logic  sq_v   [SQRT_STEPS+1];
    pipe_t sq_d   [SQRT_STEPS+1];
    logic  sq_rdy [SQRT_STEPS+1];
    logic  dv_v   [DIV_STEPS+1];
    pipe_t dv_d   [DIV_STEPS+1];
    logic  dv_rdy [DIV_STEPS+1];

    pipe_t entry_next;
    logic  entry_valid_reg;
    pipe_t entry_reg;
    logic  mul_valid_reg;
    pipe_t mul_reg;
    pipe_t mul_next;
    logic  out_valid_reg;
    logic  out_en;
    logic  mul_en;
    logic [33:0]        value_reg;
    logic [16:0]        slope_reg;
    logic signed [31:0] curv_reg;
    logic [47:0] rd;

    // threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            delta_reg <= DELTA_RESET;
        else if (cfg_we)
            delta_reg <= cfg_wdata;
    end

    // entry stage: inlier test
    always_comb
    begin
        entry_next        = '0;
        entry_next.e      = sq_error;
        entry_next.d      = delta_reg;
        entry_next.inlier = (sq_error <= 32'(delta_reg * delta_reg));
    end

    assign req_ready = !entry_valid_reg || sq_rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            entry_valid_reg <= 1'b0;
        else if (req_ready)
            entry_valid_reg <= req_valid;
    end

    always_ff @(posedge clk)
    begin
        if (req_ready)
            entry_reg <= entry_next;
    end

    assign sq_v[0] = entry_valid_reg;
    assign sq_d[0] = entry_reg;

    // square root row
    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        hld_sqrt_cell #(.STEP(SQRT_STEPS - 1 - k)) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .up_valid   (sq_v[k]),
            .up_data    (sq_d[k]),
            .up_ready   (sq_rdy[k]),
            .valid      (sq_v[k+1]),
            .data       (sq_d[k+1]),
            .down_ready (sq_rdy[k+1])
        );
    end

    // multiply stage: loss value and divisors
    always_comb
    begin
        mul_next        = sq_d[SQRT_STEPS];
        rd              = sq_d[SQRT_STEPS].root * sq_d[SQRT_STEPS].d;
        mul_next.value  = 34'(rd[47:15]) - 34'(sq_d[SQRT_STEPS].d * sq_d[SQRT_STEPS].d);
        mul_next.div_s  = sq_d[SQRT_STEPS].root;
        mul_next.rem_sl = {1'b0, sq_d[SQRT_STEPS].d, 15'd0};
        mul_next.q_sl   = '0;
        mul_next.div_c  = sq_d[SQRT_STEPS].e * sq_d[SQRT_STEPS].root;
        mul_next.rem_c  = {32'd0, sq_d[SQRT_STEPS].d, 16'd0};
        mul_next.q_c    = '0;
    end

    assign mul_en                = !mul_valid_reg || dv_rdy[0];
    assign sq_rdy[SQRT_STEPS]    = mul_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mul_valid_reg <= 1'b0;
        else if (mul_en)
            mul_valid_reg <= sq_v[SQRT_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (mul_en)
            mul_reg <= mul_next;
    end

    assign dv_v[0] = mul_valid_reg;
    assign dv_d[0] = mul_reg;

    // divider row: slope and curvature
    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        hld_div_cell #(.STEP(DIV_STEPS - 1 - k)) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .up_valid   (dv_v[k]),
            .up_data    (dv_d[k]),
            .up_ready   (dv_rdy[k]),
            .valid      (dv_v[k+1]),
            .data       (dv_d[k+1]),
            .down_ready (dv_rdy[k+1])
        );
    end

    // output register with inlier override
    assign out_en            = !out_valid_reg || rsp_ready;
    assign dv_rdy[DIV_STEPS] = out_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_en)
            out_valid_reg <= dv_v[DIV_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (out_en)
        begin
            if (dv_d[DIV_STEPS].inlier)
            begin
                value_reg <= {2'b00, dv_d[DIV_STEPS].e};
                slope_reg <= SLOPE_ONE;
                curv_reg  <= '0;
            end
            else
            begin
                value_reg <= dv_d[DIV_STEPS].value;
                slope_reg <= dv_d[DIV_STEPS].q_sl;
                curv_reg  <= 32'(-$signed({1'b0, dv_d[DIV_STEPS].q_c}));
            end
        end
    end

    assign rsp_valid = out_valid_reg;
    assign value     = value_reg;
    assign slope     = slope_reg;
    assign curvature = curv_reg;

    // checks
    a_curv_nonpos: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(curvature > 0))
        else $error("curvature positive");

    a_slope_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> slope <= SLOPE_ONE)
        else $error("slope above one");

    a_unit_slope_flat: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && slope == SLOPE_ONE && value <= 34'hFFFFFFFF
         && curvature == 0) || !rsp_valid || slope != SLOPE_ONE || curvature != 0)
        else $error("inlier result inconsistent");

    a_entry_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> entry_valid_reg)
        else $error("accepted request lost at entry");

endmodule
